// ===== hdl/spi_pkg.sv =====
`default_nettype none
package spi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 4;

  // fill state of the queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // queued item, lowest bits first: hit, start xyz, |end-start| xyz,
  // sign of end-start xyz, |r1|, |r1|+|r2|
  function automatic int item_width(input int w);
    return 10 * w + 10;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/spi_front.sv =====
`default_nettype none
module spi_front import spi_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [10*W-1:0]            in_data,
  output logic                            q_push,
  input  wire queue_stat_t                q_stat,
  output logic [item_width(W)-1:0]        q_data
);

  localparam int RW = 2 * W + 2;
  localparam int AW = 2 * W + 1;
  localparam int DW = 2 * W + 2;

  logic signed [W-1:0]   nrm [3];
  logic signed [W-1:0]   st  [3];
  logic signed [W-1:0]   ed  [3];
  logic signed [W-1:0]   off;

  logic                  v1;
  logic signed [2*W-1:0] ps1 [3];
  logic signed [2*W-1:0] pe1 [3];
  logic signed [W-1:0]   s1  [3];
  logic signed [W-1:0]   e1  [3];
  logic signed [W-1:0]   d1;

  logic                  v2;
  logic signed [RW-1:0]  r1;
  logic signed [RW-1:0]  r2;
  logic signed [W-1:0]   s2  [3];
  logic signed [W-1:0]   e2  [3];

  logic                  en;
  logic [RW-1:0]         abs1;
  logic [RW-1:0]         abs2;
  logic [AW-1:0]         a1;
  logic [DW-1:0]         dsum;
  logic signed [W:0]     dif  [3];
  logic [W:0]            dmag [3];
  logic [2:0]            dneg;
  logic                  hit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nrm[c] = in_data[c*W +: W];
      st[c]  = in_data[(4+c)*W +: W];
      ed[c]  = in_data[(7+c)*W +: W];
    end
    off = in_data[3*W +: W];
  end

  // the whole front stalls only when its last stage cannot enter the queue
  assign en       = !(v2 && q_stat.full);
  assign in_ready = en;
  assign q_push   = v2 && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ps1[c] <= nrm[c] * st[c];
        pe1[c] <= nrm[c] * ed[c];
        s1[c]  <= st[c];
        e1[c]  <= ed[c];
        s2[c]  <= s1[c];
        e2[c]  <= e1[c];
      end
      d1 <= off;
      r1 <= RW'(ps1[0]) + RW'(ps1[1]) + RW'(ps1[2]) - (RW'(d1) <<< F);
      r2 <= RW'(pe1[0]) + RW'(pe1[1]) + RW'(pe1[2]) - (RW'(d1) <<< F);
    end
  end

  // ends on opposite sides: |r2 - r1| = |r1| + |r2| and lambda >= 0
  always_comb begin
    hit  = r1[RW-1] ^ r2[RW-1];
    abs1 = r1[RW-1] ? RW'(-r1) : RW'(r1);
    abs2 = r2[RW-1] ? RW'(-r2) : RW'(r2);
    a1   = abs1[AW-1:0];
    dsum = DW'(abs1[AW-1:0]) + DW'(abs2[AW-1:0]);
    for (int c = 0; c < 3; c++) begin
      dif[c]  = (W+1)'(e2[c]) - (W+1)'(s2[c]);
      dneg[c] = dif[c][W];
      dmag[c] = dif[c][W] ? (W+1)'(-dif[c]) : (W+1)'(dif[c]);
    end
  end

  assign q_data = {dsum, a1, dneg, dmag[2], dmag[1], dmag[0],
                   s2[2], s2[1], s2[0], hit};

endmodule
`default_nettype wire

// ===== hdl/spi_queue.sv =====
`default_nettype none
module spi_queue import spi_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] din,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      dout,
  output queue_stat_t            stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [CNT_W-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign dout       = mem[rp];
  assign stat.full  = (cnt == CNT_W'(DEPTH));
  assign stat.empty = (cnt == '0);

endmodule
`default_nettype wire

// ===== hdl/spi_back.sv =====
`default_nettype none
module spi_back import spi_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  output logic                     q_pop,
  input  wire queue_stat_t         q_stat,
  input  wire logic [item_width(W)-1:0] q_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_hit,
  output logic [3*W-1:0]           out_point
);

  localparam int AW = 2 * W + 1;
  localparam int DW = 2 * W + 2;
  localparam int QB = W + 1;
  localparam int PW = AW + QB;

  logic [DW-1:0]       h_den;
  logic [AW-1:0]       h_num;
  logic [2:0]          h_neg;
  logic [W:0]          h_mag [3];
  logic [W-1:0]        h_st  [3];
  logic                h_hit;

  logic                en;

  // partial products
  logic                va;
  logic [2*W+1:0]      ppl [3];
  logic [2*W:0]        pph [3];
  logic                ha;
  logic [W-1:0]        sa  [3];
  logic [2:0]          na;
  logic [DW-1:0]       da;
  logic [PW-1:0]       prod [3];

  // restoring divider, one quotient bit per stage
  logic                vd  [0:QB];
  logic                hd  [0:QB];
  logic [W-1:0]        sd  [0:QB][3];
  logic [2:0]          nd  [0:QB];
  logic [DW-1:0]       dd  [0:QB];
  logic [DW-1:0]       rem [0:QB][3];
  logic [QB-1:0]       lo  [0:QB][3];
  logic [DW:0]         trial [0:QB-1][3];
  logic                ge    [0:QB-1][3];

  // rounding and sign
  logic                vr;
  logic                hr;
  logic [W-1:0]        sr  [3];
  logic signed [W+1:0] offr [3];
  logic                rup  [3];
  logic [W+1:0]        qrnd [3];

  logic signed [W+1:0] sum [3];
  logic [W-1:0]        sat [3];

  assign {h_den, h_num, h_neg, h_mag[2], h_mag[1], h_mag[0],
          h_st[2], h_st[1], h_st[0], h_hit} = q_data;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_stat.empty;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PW'(ppl[c]) + (PW'(pph[c]) << QB);
    end
    for (int k = 0; k < QB; k++) begin
      for (int c = 0; c < 3; c++) begin
        trial[k][c] = {rem[k][c], lo[k][c][QB-1]};
        ge[k][c]    = (trial[k][c] >= {1'b0, dd[k]});
      end
    end
    for (int c = 0; c < 3; c++) begin
      rup[c]  = ({rem[QB][c], 1'b0} >= {1'b0, dd[QB]});
      qrnd[c] = (W+2)'(lo[QB][c]) + (W+2)'(rup[c]);
      sum[c]  = $signed((W+2)'($signed(sr[c]))) + offr[c];
      if (sum[c][W+1:W-1] == 3'b000 || sum[c][W+1:W-1] == 3'b111) begin
        sat[c] = sum[c][W-1:0];
      end else if (sum[c][W+1]) begin
        sat[c] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat[c] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vr        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= QB; k++) vd[k] <= 1'b0;
    end else if (en) begin
      va    <= q_pop;
      vd[0] <= va;
      for (int k = 0; k < QB; k++) vd[k+1] <= vd[k];
      vr        <= vd[QB];
      out_valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ppl[c] <= (2*W+2)'(h_num[W:0]) * (2*W+2)'(h_mag[c]);
        pph[c] <= (2*W+1)'(h_num[AW-1:W+1]) * (2*W+1)'(h_mag[c]);
        sa[c]  <= h_st[c];
      end
      ha <= h_hit;
      na <= h_neg;
      da <= h_den;

      hd[0] <= ha;
      nd[0] <= na;
      dd[0] <= da;
      for (int c = 0; c < 3; c++) begin
        sd[0][c]  <= sa[c];
        rem[0][c] <= DW'(prod[c][PW-1:QB]);
        lo[0][c]  <= prod[c][QB-1:0];
      end

      for (int k = 0; k < QB; k++) begin
        hd[k+1] <= hd[k];
        nd[k+1] <= nd[k];
        dd[k+1] <= dd[k];
        for (int c = 0; c < 3; c++) begin
          sd[k+1][c]  <= sd[k][c];
          rem[k+1][c] <= ge[k][c] ? DW'(trial[k][c] - {1'b0, dd[k]})
                                  : trial[k][c][DW-1:0];
          lo[k+1][c]  <= {lo[k][c][QB-2:0], ge[k][c]};
        end
      end

      hr <= hd[QB];
      for (int c = 0; c < 3; c++) begin
        sr[c]   <= sd[QB][c];
        offr[c] <= nd[QB][c] ? -$signed(qrnd[c]) : $signed(qrnd[c]);
      end

      out_hit <= hr;
      for (int c = 0; c < 3; c++) begin
        out_point[c*W +: W] <= hr ? sat[c] : '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/segment_plane_intersection_core.sv =====
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: normal xyz, offset, start xyz, end xyz
// m_*       out  m_tvalid/m_tready  tdata: point xyz; tuser: hit
//
// One segment per cycle sustained while m_tready stays high. Pipeline stages:
// two front stages (products, side values), queue, partial
// products, product sum, one divider stage per quotient bit, round, saturate.
// Synchronous reset empties the pipeline and the queue.
// A stalled output holds the back end; the front keeps filling the queue until it is full.
module segment_plane_intersection_core import spi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // normal_x, normal_y, normal_z, plane_offset, start_x, start_y, start_z,
  // end_x, end_y, end_z
  input  wire logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // point_x, point_y, point_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
  // hit
  output logic [0:0]                m_tuser
);

  localparam int IW     = item_width(COORD_WIDTH);
  localparam int OUT_TW = ((3 * COORD_WIDTH + 7) / 8) * 8;

  logic                     q_push;
  logic                     q_pop;
  queue_stat_t              q_stat;
  logic [IW-1:0]            q_din;
  logic [IW-1:0]            q_dout;
  logic [3*COORD_WIDTH-1:0] point;
  logic                     hit;

  spi_front #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata[10*COORD_WIDTH-1:0]),
    .q_push   (q_push),
    .q_stat   (q_stat),
    .q_data   (q_din)
  );

  spi_queue #(.DATA_W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  spi_back #(.W(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_pop     (q_pop),
    .q_stat    (q_stat),
    .q_data    (q_dout),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (hit),
    .out_point (point)
  );

  assign m_tdata    = OUT_TW'(point);
  assign m_tuser[0] = hit;

endmodule
`default_nettype wire

// ===== tb/spi_checker.sv =====
`default_nettype none
module spi_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [319:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [95:0]  m_tdata,
  input  wire logic [0:0]   m_tuser,
  output int                errors,
  output int                pending,
  output int                results,
  output int                hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } crossing_t;

  crossing_t expected_crossings[$];

  localparam logic signed [127:0] COORD_MAX = 128'sd2147483647;
  localparam logic signed [127:0] COORD_MIN = -128'sd2147483648;

  // exact side values, then rounded offset along the segment per axis
  function automatic crossing_t intersect_segment(input logic [319:0] d);
    logic signed [127:0] n[3], s[3], e[3];
    logic signed [127:0] offs, r1, r2, den, aden, prod, aprod, q, rem, sum;
    crossing_t res;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      n[c] = $signed(d[32*c +: 32]);
      s[c] = $signed(d[32*(4+c) +: 32]);
      e[c] = $signed(d[32*(7+c) +: 32]);
    end
    offs = $signed(d[96 +: 32]);
    r1 = n[0]*s[0] + n[1]*s[1] + n[2]*s[2] - (offs <<< 16);
    r2 = n[0]*e[0] + n[1]*e[1] + n[2]*e[2] - (offs <<< 16);
    den = r2 - r1;
    if ((r1 < 0) == (r2 < 0) || den == 0) return res;
    aden = (den < 0) ? -den : den;
    for (int c = 0; c < 3; c++) begin
      prod = -r1 * (e[c] - s[c]);
      aprod = (prod < 0) ? -prod : prod;
      q = aprod / aden;
      rem = aprod % aden;
      if (2 * rem >= aden) q = q + 1;   // halves away from zero
      if ((prod < 0) != (den < 0)) q = -q;
      sum = s[c] + q;
      if (sum > COORD_MAX) sum = COORD_MAX;
      else if (sum < COORD_MIN) sum = COORD_MIN;
      case (c)
        0: res.px = sum[31:0];
        1: res.py = sum[31:0];
        default: res.pz = sum[31:0];
      endcase
    end
    res.hit = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = expected_crossings.size();

  initial begin
    errors = 0;
    results = 0;
    hits = 0;
  end

  always @(posedge clk) begin
    crossing_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_crossings.push_back(intersect_segment(s_tdata));
      if (m_tvalid && m_tready) begin
        results++;
        if (m_tuser[0]) hits++;
        if (expected_crossings.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding", $realtime);
          errors++;
        end else begin
          want = expected_crossings.pop_front();
          if (m_tuser[0] !== want.hit) report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
          if (m_tdata[31:0] !== want.px) report_mismatch("point_x", m_tdata[31:0], want.px);
          if (m_tdata[63:32] !== want.py) report_mismatch("point_y", m_tdata[63:32], want.py);
          if (m_tdata[95:64] !== want.pz) report_mismatch("point_z", m_tdata[95:64], want.pz);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_segment_plane_intersection_core.sv =====
`default_nettype none
module tb_segment_plane_intersection_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;
  localparam int N_RANDOM = 380;
  localparam int CALM_FROM = 330;   // no idling from here on

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [319:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [0:0]   m_tuser;

  int  errors, pending, results, hits;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  segment_plane_intersection_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  spi_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending), .results(results), .hits(hits)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [319:0] segment(input int nx, ny, nz, d,
                                            input int sx, sy, sz, ex, ey, ez);
    return {ez, ey, ex, sz, sy, sx, d, nz, ny, nx};
  endfunction

  function automatic int near_value(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly small planes and points so that crossings are common
  function automatic logic [319:0] random_segment();
    logic [319:0] item;
    int unsigned mode;
    mode = $urandom_range(0, 19);
    for (int f = 0; f < 10; f++) begin
      if (mode < 12) item[32*f +: 32] = (f < 3) ? near_value(4 * ONE) : near_value(64 * ONE);
      else if (mode < 17) item[32*f +: 32] = $urandom;
      else item[32*f +: 32] = (f < 4) ? $urandom : near_value(ONE);
    end
    return item;
  endfunction

  task automatic send_segment(input logic [319:0] item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        for (int k = 0; k < 300; k++) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [319:0] directed[$];
    int tail;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero normal, parallel, ends on the plane, same side, extremes, rounding
    directed.push_back(segment(0, 0, 0, 0, ONE, 2*ONE, 3*ONE, -ONE, -ONE, -ONE));
    directed.push_back(segment(0, 0, 0, -5*ONE, ONE, 0, 0, -ONE, 0, 0));
    directed.push_back(segment(0, 0, ONE, 0, 0, 0, -ONE, 0, 0, ONE));
    directed.push_back(segment(0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE, -ONE));
    directed.push_back(segment(0, 0, ONE, 0, 3*ONE, 0, -2*ONE, 0, 0, 0));
    directed.push_back(segment(ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 9*ONE, -4*ONE));
    directed.push_back(segment(ONE, ONE, ONE, 10*ONE, 0, 0, 0, ONE, ONE, ONE));
    directed.push_back(segment(ONE, 0, 0, 1, 0, 0, 0, 3, 7, -5));
    directed.push_back(segment(ONE, 0, 0, 1, 0, 5, 0, 2, 0, 0));
    directed.push_back(segment(-ONE, 0, 0, 0, -ONE, 0, 0, ONE, 2*ONE, 3*ONE));
    directed.push_back(segment(ONE, ONE, ONE, 0, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    directed.push_back(segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               32'h80000000, 32'h80000000));
    directed.push_back(segment(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000));
    directed.push_back(segment(32'h7fffffff, 32'h80000000, 1, 32'h80000000,
                               32'h80000000, 32'h7fffffff, -1, 32'h7fffffff,
                               32'h80000000, 32'hffffffff));
    directed.push_back(segment(-1, -1, -1, -1, -1, -1, -1, 1, 1, 1));
    directed.push_back(segment(1, 0, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0));
    directed.push_back(segment(0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0));
    directed.push_back(segment(ONE, ONE, 0, 0, -ONE, 0, 5, 0, ONE, -5));
    foreach (directed[i]) send_segment(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) hold_req = 1'b1;   // sender keeps offering through the stall
      if (i == 200) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (i == CALM_FROM) calm = 1'b1;
      send_segment(random_segment());
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    tail = 0;
    while (tail < 100) begin
      @(posedge clk);
      tail++;
    end

    $display("%0d segments tested: %0d crossings, %0d misses", results, hits, results - hits);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/spi_pkg.sv
hdl/spi_front.sv
hdl/spi_queue.sv
hdl/spi_back.sv
hdl/segment_plane_intersection_core.sv
tb/spi_checker.sv
tb/tb_segment_plane_intersection_core.sv
